FILE: hw/rtl/versioned_entity_handle_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the entity handle table
// Shorthand for clocked assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef VERSIONED_ENTITY_HANDLE_TABLE_MACROS_SVH
`define VERSIONED_ENTITY_HANDLE_TABLE_MACROS_SVH

// same-cycle implication
`define VEHT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define VEHT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: hw/rtl/veht_pkg.sv
// ----------------------------------------------------------------------------
// veht_pkg
// Transaction types and codes of the entity handle table.
// ----------------------------------------------------------------------------
package veht_pkg;

  localparam logic [3:0] CMD_CREATE   = 4'd0;
  localparam logic [3:0] CMD_DESTROY  = 4'd1;
  localparam logic [3:0] CMD_FRAME    = 4'd2;
  localparam logic [3:0] CMD_ALIVE    = 4'd3;
  localparam logic [3:0] CMD_GET      = 4'd4;
  localparam logic [3:0] CMD_HASCOMP  = 4'd5;
  localparam logic [3:0] CMD_ADDCOMP  = 4'd6;
  localparam logic [3:0] CMD_REMCOMP  = 4'd7;
  localparam logic [3:0] CMD_ADDTAG   = 4'd8;
  localparam logic [3:0] CMD_REMTAG   = 4'd9;
  localparam logic [3:0] CMD_HASTAG   = 4'd10;
  localparam logic [3:0] CMD_SETTAGS  = 4'd11;
  localparam logic [3:0] CMD_GETTAGS  = 4'd12;
  localparam logic [3:0] CMD_GETCOMPS = 4'd13;
  localparam logic [3:0] CMD_QUERY    = 4'd14;
  localparam logic [3:0] CMD_NONE     = 4'd15;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_ALIVE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_MISSING   = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

  typedef struct packed {
    logic [3:0]  command;
    logic [5:0]  entity_id;
    logic [15:0] entity_version;
    logic [4:0]  component_index;
    logic [3:0]  tag_index;
    logic [31:0] component_mask;
    logic [15:0] tag_mask;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  out_id;
    logic [15:0] out_version;
    logic        answer;
    logic [31:0] component_bits;
    logic [15:0] tag_bits;
    logic        match_valid;
    logic        last;
  } res_t;

endpackage

FILE: hw/rtl/versioned_entity_handle_table.sv
// ----------------------------------------------------------------------------
// versioned_entity_handle_table
// Generational slot map of entity handles with component and tag bits.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken when start is high and busy is low.
//   Results leave on res_o, each qualified by res_valid_o for one cycle;
//   the receiver cannot stall, so every strobe is a delivered result.
//   The final result of a command carries last.
// Sequence:
//   Create with an empty free list, range errors and empty-table frame or
//   query answer in the cycle after start; other single-slot commands
//   read the entry, then modify and write it back; a create from the free
//   list reads the list, then the entry, then writes back.
//   Frame sweeps one slot a cycle up to slots_used. Query walks one slot a
//   cycle and holds each match until the next is found, so the final match
//   carries last. The entry and free-list memories have registered reads.
// Reset:
//   Clears the slot count and free list; memories need no clearing since
//   only written slots are ever read.
// ----------------------------------------------------------------------------
module versioned_entity_handle_table #(
  parameter int ENTITY_SLOTS    = 64,
  parameter int COMPONENT_TYPES = 32,
  parameter int TAG_BITS        = 16,
  parameter int VERSION_WIDTH   = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  veht_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  output veht_pkg::res_t res_o
);

  localparam int IDW  = $clog2(ENTITY_SLOTS);
  localparam int CNTW = $clog2(ENTITY_SLOTS + 1);
  localparam int SW   = CNTW + 1;

  typedef struct packed {
    logic [VERSION_WIDTH-1:0]   version;
    logic                       alive;
    logic                       created;
    logic                       destroyed;
    logic [COMPONENT_TYPES-1:0] own;
    logic [TAG_BITS-1:0]        tags;
  } ent_t;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIFO  = 3'd1;
  localparam logic [2:0] S_RMW   = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_QUERY = 3'd4;
  localparam logic [2:0] S_QEND  = 3'd5;

  ent_t           ent_mem [ENTITY_SLOTS];
  logic [IDW-1:0] fifo_mem [ENTITY_SLOTS];
  ent_t           ent_rd_q;
  logic [IDW-1:0] fifo_rd_q;

  logic [2:0]               state_q, state_d;
  veht_pkg::cmd_t           req_q, req_d;
  logic [IDW-1:0]           slot_q, slot_d;
  logic [IDW-1:0]           idx_q, idx_d;
  logic [CNTW-1:0]          used_q, used_d;
  logic [IDW-1:0]           head_q, head_d;
  logic [CNTW-1:0]          count_q, count_d;
  logic                     pend_q, pend_d;
  logic [IDW-1:0]           pend_id_q, pend_id_d;
  logic [VERSION_WIDTH-1:0] pend_ver_q, pend_ver_d;
  veht_pkg::res_t           res_q, res_d;
  logic                     res_valid_q, res_valid_d;

  logic           ent_re, ent_we, fifo_re, fifo_we;
  logic [IDW-1:0] ent_raddr, ent_waddr, fifo_waddr;
  ent_t           ent_wdata, e, w;

  logic                       live, last_idx, match, ci_ok, ti_ok;
  logic [COMPONENT_TYPES-1:0] cbit, cmask;
  logic [TAG_BITS-1:0]        tbit, tmask;
  logic [SW-1:0]              tail_sum;
  logic [IDW-1:0]             tail;

  function automatic veht_pkg::res_t mk_res(logic [2:0] st, logic [IDW-1:0] id,
                                            logic [VERSION_WIDTH-1:0] ver,
                                            logic ans, logic [31:0] comps,
                                            logic [15:0] tags, logic mv,
                                            logic lst);
    veht_pkg::res_t r;
    r.status         = st;
    r.out_id         = 6'(id);
    r.out_version    = 16'(ver);
    r.answer         = ans;
    r.component_bits = comps;
    r.tag_bits       = tags;
    r.match_valid    = mv;
    r.last           = lst;
    return r;
  endfunction

  always_comb begin
    e        = ent_rd_q;
    live     = (32'(e.version) == 32'(req_q.entity_version)) && (e.alive || e.created);
    last_idx = (CNTW'(idx_q) + CNTW'(1)) == used_q;
    cmask    = COMPONENT_TYPES'(req_q.component_mask);
    tmask    = TAG_BITS'(req_q.tag_mask);
    ci_ok    = 32'(req_q.component_index) < COMPONENT_TYPES;
    ti_ok    = (req_q.tag_index != 4'd0) && (32'(req_q.tag_index) < TAG_BITS);
    cbit     = COMPONENT_TYPES'(1) << req_q.component_index;
    tbit     = TAG_BITS'(1) << req_q.tag_index;
    match    = (e.alive || e.created) && ((e.own & cmask) == cmask)
               && ((e.tags & tmask) == tmask);
    tail_sum = SW'(head_q) + SW'(count_q);
    tail     = (tail_sum >= SW'(ENTITY_SLOTS)) ? IDW'(tail_sum - SW'(ENTITY_SLOTS))
                                               : IDW'(tail_sum);
    w        = e;

    state_d     = state_q;
    req_d       = req_q;
    slot_d      = slot_q;
    idx_d       = idx_q;
    used_d      = used_q;
    head_d      = head_q;
    count_d     = count_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    pend_ver_d  = pend_ver_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    ent_re      = 1'b0;
    ent_raddr   = '0;
    ent_we      = 1'b0;
    ent_waddr   = '0;
    ent_wdata   = e;
    fifo_re     = 1'b0;
    fifo_we     = 1'b0;
    fifo_waddr  = tail;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = cmd_i;
          unique case (cmd_i.command)
            veht_pkg::CMD_CREATE: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                if (used_q == CNTW'(ENTITY_SLOTS)) begin
                  res_d = mk_res(veht_pkg::ST_FULL, '0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
                end else begin
                  ent_we              = 1'b1;
                  ent_waddr           = IDW'(used_q);
                  ent_wdata           = '0;
                  ent_wdata.created   = 1'b1;
                  used_d              = used_q + CNTW'(1);
                  res_d = mk_res(veht_pkg::ST_OK, IDW'(used_q), '0, 1'b0, '0, '0,
                                 1'b0, 1'b1);
                end
              end else begin
                fifo_re = 1'b1;
                head_d  = (head_q == IDW'(ENTITY_SLOTS - 1)) ? '0 : head_q + IDW'(1);
                count_d = count_q - CNTW'(1);
                state_d = S_FIFO;
              end
            end
            veht_pkg::CMD_FRAME, veht_pkg::CMD_QUERY: begin
              if (used_q == '0) begin
                res_valid_d = 1'b1;
                res_d = mk_res(veht_pkg::ST_OK, '0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
              end else begin
                ent_re  = 1'b1;
                idx_d   = '0;
                pend_d  = 1'b0;
                state_d = (cmd_i.command == veht_pkg::CMD_FRAME) ? S_SWEEP : S_QUERY;
              end
            end
            veht_pkg::CMD_NONE: begin
            end
            default: begin
              if (32'(cmd_i.entity_id) >= 32'(used_q)) begin
                res_valid_d = 1'b1;
                res_d = mk_res(veht_pkg::ST_RANGE, '0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
              end else begin
                ent_re    = 1'b1;
                ent_raddr = IDW'(cmd_i.entity_id);
                slot_d    = IDW'(cmd_i.entity_id);
                state_d   = S_RMW;
              end
            end
          endcase
        end
      end
      S_FIFO: begin
        ent_re    = 1'b1;
        ent_raddr = fifo_rd_q;
        slot_d    = fifo_rd_q;
        state_d   = S_RMW;
      end
      S_RMW: begin
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
        ent_waddr   = slot_q;
        res_d = mk_res(veht_pkg::ST_OK, '0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
        unique case (req_q.command)
          veht_pkg::CMD_CREATE: begin
            ent_we            = 1'b1;
            ent_wdata.version = e.version + VERSION_WIDTH'(1);
            ent_wdata.created = 1'b1;
            res_d.out_id      = 6'(slot_q);
            res_d.out_version = 16'(e.version + VERSION_WIDTH'(1));
          end
          veht_pkg::CMD_DESTROY: begin
            if (!live) begin
              res_d.status = veht_pkg::ST_NOT_ALIVE;
            end else if (count_q == CNTW'(ENTITY_SLOTS)) begin
              res_d.status = veht_pkg::ST_FULL;
            end else begin
              fifo_we             = 1'b1;
              count_d             = count_q + CNTW'(1);
              ent_we              = 1'b1;
              ent_wdata.destroyed = 1'b1;
            end
          end
          veht_pkg::CMD_ALIVE: res_d.answer = live;
          veht_pkg::CMD_GET: begin
            res_d.out_id      = 6'(slot_q);
            res_d.out_version = 16'(e.version);
          end
          veht_pkg::CMD_HASCOMP, veht_pkg::CMD_ADDCOMP, veht_pkg::CMD_REMCOMP: begin
            if (!ci_ok) begin
              res_d.status = veht_pkg::ST_MISSING;
            end else if (req_q.command == veht_pkg::CMD_HASCOMP) begin
              res_d.answer = live && ((e.own & cbit) != '0);
            end else if (!live) begin
              res_d.status = veht_pkg::ST_NOT_ALIVE;
            end else if (req_q.command == veht_pkg::CMD_ADDCOMP) begin
              ent_we        = 1'b1;
              ent_wdata.own = e.own | cbit;
            end else if ((e.own & cbit) != '0) begin
              ent_we        = 1'b1;
              ent_wdata.own = e.own & ~cbit;
            end else begin
              res_d.status = veht_pkg::ST_MISSING;
            end
          end
          veht_pkg::CMD_ADDTAG, veht_pkg::CMD_REMTAG, veht_pkg::CMD_HASTAG: begin
            if (!live) begin
              res_d.status = veht_pkg::ST_NOT_ALIVE;
            end else if (!ti_ok) begin
              res_d.status = veht_pkg::ST_RANGE;
            end else if (req_q.command == veht_pkg::CMD_ADDTAG) begin
              ent_we         = 1'b1;
              ent_wdata.tags = e.tags | tbit;
            end else if (req_q.command == veht_pkg::CMD_REMTAG) begin
              ent_we         = 1'b1;
              ent_wdata.tags = e.tags & ~tbit;
            end else begin
              res_d.answer = (e.tags & tbit) != '0;
            end
          end
          veht_pkg::CMD_SETTAGS: begin
            if (!live) begin
              res_d.status = veht_pkg::ST_NOT_ALIVE;
            end else begin
              ent_we         = 1'b1;
              ent_wdata.tags = tmask;
            end
          end
          veht_pkg::CMD_GETTAGS: begin
            if (!live) res_d.status = veht_pkg::ST_NOT_ALIVE;
            else res_d.tag_bits = 16'(e.tags);
          end
          default: begin
            if (!live) res_d.status = veht_pkg::ST_NOT_ALIVE;
            else res_d.component_bits = 32'(e.own);
          end
        endcase
      end
      S_SWEEP: begin
        if (e.destroyed) begin
          w.alive     = 1'b0;
          w.destroyed = 1'b0;
          w.created   = 1'b0;
          w.own       = '0;
          w.tags      = '0;
        end
        if (w.created) begin
          w.created = 1'b0;
          w.alive   = 1'b1;
        end
        ent_we    = 1'b1;
        ent_waddr = idx_q;
        ent_wdata = w;
        if (last_idx) begin
          res_valid_d = 1'b1;
          res_d   = mk_res(veht_pkg::ST_OK, '0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
          state_d = S_IDLE;
        end else begin
          ent_re    = 1'b1;
          ent_raddr = idx_q + IDW'(1);
          idx_d     = idx_q + IDW'(1);
        end
      end
      S_QUERY: begin
        if (match) begin
          if (pend_q) begin
            res_valid_d = 1'b1;
            res_d = mk_res(veht_pkg::ST_OK, pend_id_q, pend_ver_q, 1'b0, '0, '0,
                           1'b1, 1'b0);
          end
          pend_d     = 1'b1;
          pend_id_d  = idx_q;
          pend_ver_d = e.version;
        end
        if (last_idx) begin
          state_d = S_QEND;
        end else begin
          ent_re    = 1'b1;
          ent_raddr = idx_q + IDW'(1);
          idx_d     = idx_q + IDW'(1);
        end
      end
      S_QEND: begin
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
        if (pend_q) begin
          res_d = mk_res(veht_pkg::ST_OK, pend_id_q, pend_ver_q, 1'b0, '0, '0, 1'b1,
                         1'b1);
        end else begin
          res_d = mk_res(veht_pkg::ST_OK, '0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (ent_re) ent_rd_q <= ent_mem[ent_raddr];
    if (fifo_we) fifo_mem[fifo_waddr] <= slot_q;
    if (fifo_re) fifo_rd_q <= fifo_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      head_q      <= head_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    slot_q     <= slot_d;
    idx_q      <= idx_d;
    pend_id_q  <= pend_id_d;
    pend_ver_q <= pend_ver_d;
    res_q      <= res_d;
  end

  assign busy        = state_q != S_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: hw/rtl/veht_checker.sv
// ----------------------------------------------------------------------------
// veht_checker
// Port-level checks of the entity handle table, bound to the top level.
// ----------------------------------------------------------------------------
`include "versioned_entity_handle_table_macros.svh"

module veht_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input veht_pkg::cmd_t cmd_i,
  input logic           res_valid_o,
  input veht_pkg::res_t res_o
);

  `VEHT_ASSERT_NEXT(a_none_silent, clk_i, rst_ni, start && !busy && cmd_i.command == veht_pkg::CMD_NONE, !res_valid_o)
  `VEHT_ASSERT_NOW(a_more_only_query, clk_i, rst_ni, res_valid_o && !res_o.last, res_o.match_valid)
  `VEHT_ASSERT_NOW(a_match_ok, clk_i, rst_ni, res_valid_o && res_o.match_valid, res_o.status == veht_pkg::ST_OK && !res_o.answer)

endmodule

bind versioned_entity_handle_table veht_checker u_veht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .cmd_i       (cmd_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

FILE: tb/sv/versioned_entity_handle_table_tb.sv
// ----------------------------------------------------------------------------
// versioned_entity_handle_table_tb
// Self-checking bench: directed command cases, random lifecycles of entity
// handles and a table-full case, with every result compared against an in-bench slot map.
// ----------------------------------------------------------------------------
module versioned_entity_handle_table_tb;

  localparam int SLOTS = 64;
  localparam int NCOMP = 32;
  localparam int NTAG  = 16;
  localparam int WDOG  = 4000;
  localparam int EXPD  = 1024;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  veht_pkg::cmd_t cmd_i;
  logic           res_valid_o;
  veht_pkg::res_t res_o;

  versioned_entity_handle_table uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cmd_i(cmd_i), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  // slot map mirror
  logic [15:0] slot_ver[SLOTS];
  logic        slot_alive[SLOTS];
  logic        slot_pcreate[SLOTS];
  logic        slot_pdestroy[SLOTS];
  logic [31:0] slot_comps[SLOTS];
  logic [15:0] slot_tags[SLOTS];
  logic [5:0]  free_list[SLOTS];
  int          free_head;
  int          free_count;
  int          slots_used;

  // expected transactions, in order
  veht_pkg::res_t exp_fifo[EXPD];
  int             exp_wr;
  int             exp_rd;
  int             errors;
  int             idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void exp_store(input veht_pkg::res_t r);
    exp_fifo[exp_wr % EXPD] = r;
    exp_wr++;
  endfunction

  function automatic veht_pkg::res_t exp_take();
    veht_pkg::res_t r;
    r = exp_fifo[exp_rd % EXPD];
    exp_rd++;
    return r;
  endfunction

  function automatic veht_pkg::cmd_t random_cmd();
    logic [95:0] rnd;
    rnd = {$urandom, $urandom, $urandom};
    return rnd[$bits(veht_pkg::cmd_t)-1:0];
  endfunction

  function automatic veht_pkg::res_t blank_result();
    veht_pkg::res_t r;
    r = '0;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic is_live(int id, logic [15:0] ver);
    return slot_ver[id] == ver && (slot_alive[id] || slot_pcreate[id]);
  endfunction

  task automatic predict_command(input veht_pkg::cmd_t c);
    veht_pkg::res_t r;
    int             id;
    int             slot;
    int             n;
    logic           live;
    logic [31:0]    cbit;
    logic [15:0]    tbit;
    r = blank_result();
    id = int'(c.entity_id);
    case (c.command)
      veht_pkg::CMD_CREATE: begin
        if (free_count == 0 && slots_used >= SLOTS) begin
          r.status = veht_pkg::ST_FULL;
        end else begin
          if (free_count == 0) begin
            slot = slots_used;
            slots_used++;
            slot_ver[slot] = 16'hFFFF;
            slot_alive[slot] = 0;
            slot_pcreate[slot] = 0;
            slot_pdestroy[slot] = 0;
            slot_comps[slot] = '0;
            slot_tags[slot] = '0;
          end else begin
            slot = int'(free_list[free_head]);
            free_head = (free_head + 1) % SLOTS;
            free_count--;
          end
          slot_ver[slot] = slot_ver[slot] + 16'd1;
          slot_pcreate[slot] = 1;
          r.out_id = 6'(slot);
          r.out_version = slot_ver[slot];
        end
        exp_store(r);
      end
      veht_pkg::CMD_FRAME: begin
        for (int i = 0; i < slots_used; i++) begin
          if (slot_pdestroy[i]) begin
            slot_alive[i] = 0;
            slot_pdestroy[i] = 0;
            slot_pcreate[i] = 0;
            slot_comps[i] = '0;
            slot_tags[i] = '0;
          end
          if (slot_pcreate[i]) begin
            slot_pcreate[i] = 0;
            slot_alive[i] = 1;
          end
        end
        exp_store(r);
      end
      veht_pkg::CMD_QUERY: begin
        n = 0;
        for (int i = 0; i < slots_used; i++) begin
          if ((slot_alive[i] || slot_pcreate[i]) &&
              (slot_comps[i] & c.component_mask) == c.component_mask &&
              (slot_tags[i] & c.tag_mask) == c.tag_mask) begin
            r = '0;
            r.out_id = 6'(i);
            r.out_version = slot_ver[i];
            r.match_valid = 1'b1;
            exp_store(r);
            n++;
          end
        end
        if (n == 0) exp_store(blank_result());
        else exp_fifo[(exp_wr - 1) % EXPD].last = 1'b1;
      end
      veht_pkg::CMD_NONE: ;
      default: begin
        if (id >= slots_used) begin
          r.status = veht_pkg::ST_RANGE;
        end else if (c.command == veht_pkg::CMD_GET) begin
          r.out_id = 6'(id);
          r.out_version = slot_ver[id];
        end else begin
          live = is_live(id, c.entity_version);
          cbit = 32'd1 << c.component_index;
          tbit = 16'd1 << c.tag_index;
          case (c.command)
            veht_pkg::CMD_DESTROY: begin
              if (!live) r.status = veht_pkg::ST_NOT_ALIVE;
              else if (free_count >= SLOTS) r.status = veht_pkg::ST_FULL;
              else begin
                free_list[(free_head + free_count) % SLOTS] = 6'(id);
                free_count++;
                slot_pdestroy[id] = 1;
              end
            end
            veht_pkg::CMD_ALIVE: r.answer = live;
            veht_pkg::CMD_HASCOMP: r.answer = live && (slot_comps[id] & cbit) != 0;
            veht_pkg::CMD_ADDCOMP: begin
              if (!live) r.status = veht_pkg::ST_NOT_ALIVE;
              else slot_comps[id] |= cbit;
            end
            veht_pkg::CMD_REMCOMP: begin
              if (!live) r.status = veht_pkg::ST_NOT_ALIVE;
              else if ((slot_comps[id] & cbit) != 0) slot_comps[id] &= ~cbit;
              else r.status = veht_pkg::ST_MISSING;
            end
            veht_pkg::CMD_ADDTAG, veht_pkg::CMD_REMTAG, veht_pkg::CMD_HASTAG: begin
              if (!live) r.status = veht_pkg::ST_NOT_ALIVE;
              else if (c.tag_index == 0) r.status = veht_pkg::ST_RANGE;
              else if (c.command == veht_pkg::CMD_ADDTAG) slot_tags[id] |= tbit;
              else if (c.command == veht_pkg::CMD_REMTAG) slot_tags[id] &= ~tbit;
              else r.answer = (slot_tags[id] & tbit) != 0;
            end
            veht_pkg::CMD_SETTAGS: begin
              if (!live) r.status = veht_pkg::ST_NOT_ALIVE;
              else slot_tags[id] = c.tag_mask;
            end
            veht_pkg::CMD_GETTAGS: begin
              if (!live) r.status = veht_pkg::ST_NOT_ALIVE;
              else r.tag_bits = slot_tags[id];
            end
            default: begin
              if (!live) r.status = veht_pkg::ST_NOT_ALIVE;
              else r.component_bits = slot_comps[id];
            end
          endcase
        end
        exp_store(r);
      end
    endcase
  endtask

  // entered just after an accepting edge; leaves at the next accepting edge
  task automatic send_command(input veht_pkg::cmd_t c);
    int gap;
    gap = $urandom_range(0, 4);
    @(negedge clk_i);
    repeat (gap) begin
      start <= 1'b0;
      cmd_i <= random_cmd();
      @(negedge clk_i);
    end
    while (busy) begin
      start <= 1'b0;
      cmd_i <= random_cmd();
      @(negedge clk_i);
    end
    cmd_i <= c;
    start <= 1'b1;
    @(posedge clk_i);
    predict_command(c);
  endtask

  task automatic release_inputs();
    @(negedge clk_i);
    start <= 1'b0;
    cmd_i <= random_cmd();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (exp_wr == exp_rd) begin
        $display("%0t: unexpected result %h", $time, res_o);
        errors++;
      end else begin
        veht_pkg::res_t e;
        e = exp_take();
        if (res_o.status !== e.status || res_o.out_id !== e.out_id ||
            res_o.out_version !== e.out_version || res_o.answer !== e.answer ||
            res_o.component_bits !== e.component_bits ||
            res_o.tag_bits !== e.tag_bits ||
            res_o.match_valid !== e.match_valid || res_o.last !== e.last) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, res_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || res_valid_o || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic veht_pkg::cmd_t random_fields(input logic [3:0] op);
    veht_pkg::cmd_t c;
    c = random_cmd();
    c.command = op;
    return c;
  endfunction

  // handle of a slot, live or stale
  function automatic veht_pkg::cmd_t on_slot(input logic [3:0] op, input logic stale);
    veht_pkg::cmd_t c;
    int             id;
    c = random_fields(op);
    if (slots_used > 0 && $urandom_range(0, 7) != 0) begin
      id = $urandom_range(0, slots_used - 1);
      c.entity_id = 6'(id);
      c.entity_version = stale ? slot_ver[id] - 16'd1 : slot_ver[id];
    end
    c.component_index = 5'($urandom_range(0, 5));
    c.tag_index = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 1)) c.component_mask &= 32'h3 << $urandom_range(0, 30);
    else c.component_mask = '0;
    if ($urandom_range(0, 1)) c.tag_mask &= 16'h6 << $urandom_range(0, 13);
    else c.tag_mask = '0;
    return c;
  endfunction

  task automatic test_directed();
    veht_pkg::cmd_t c;
    send_command(on_slot(veht_pkg::CMD_QUERY, 0));
    c = random_fields(veht_pkg::CMD_GET); c.entity_id = 6'd63; send_command(c);
    send_command(random_fields(veht_pkg::CMD_NONE));
    send_command(random_fields(veht_pkg::CMD_FRAME));
    send_command(random_fields(veht_pkg::CMD_CREATE));
    send_command(random_fields(veht_pkg::CMD_CREATE));
    c = on_slot(veht_pkg::CMD_ADDCOMP, 0); c.entity_id = 6'd0; c.entity_version = 16'd0;
    c.component_index = 5'd31; send_command(c);
    c.command = veht_pkg::CMD_HASCOMP; send_command(c);
    c.command = veht_pkg::CMD_REMCOMP; c.component_index = 5'd0; send_command(c);
    c.command = veht_pkg::CMD_ADDTAG; c.tag_index = 4'd0; send_command(c);
    c.tag_index = 4'd15; send_command(c);
    c.command = veht_pkg::CMD_HASTAG; send_command(c);
    c.command = veht_pkg::CMD_SETTAGS; c.tag_mask = 16'hFFFF; send_command(c);
    c.command = veht_pkg::CMD_GETTAGS; send_command(c);
    c.command = veht_pkg::CMD_REMTAG; send_command(c);
    c.command = veht_pkg::CMD_GETCOMPS; send_command(c);
    c.command = veht_pkg::CMD_ALIVE; send_command(c);
    c.command = veht_pkg::CMD_DESTROY; send_command(c);
    send_command(c);
    c.command = veht_pkg::CMD_ALIVE; c.entity_version = 16'hFFFF; send_command(c);
    c.command = veht_pkg::CMD_QUERY; c.component_mask = 32'hFFFF_FFFF; c.tag_mask = '0;
    send_command(c);
    send_command(random_fields(veht_pkg::CMD_FRAME));
    c.command = veht_pkg::CMD_GETTAGS; c.entity_version = 16'd0; send_command(c);
    send_command(random_fields(veht_pkg::CMD_CREATE));
  endtask

  task automatic test_random_lifecycle(input int count);
    int             k;
    veht_pkg::cmd_t c;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      if (k < 15) c = random_fields(veht_pkg::CMD_CREATE);
      else if (k < 22) c = on_slot(veht_pkg::CMD_DESTROY, 0);
      else if (k < 28) c = random_fields(veht_pkg::CMD_FRAME);
      else if (k < 34) c = on_slot(veht_pkg::CMD_QUERY, 0);
      else if (k < 40) c = random_fields(4'($urandom_range(0, 15)));
      else c = on_slot(4'($urandom_range(1, 13)), $urandom_range(0, 5) == 0);
      send_command(c);
    end
  endtask

  // fill the table to exhaust both free list and slots, then check create, get, frame and query on it
  task automatic test_table_full();
    veht_pkg::cmd_t c;
    while (slots_used < SLOTS || free_count > 0) begin
      send_command(random_fields(veht_pkg::CMD_CREATE));
    end
    send_command(random_fields(veht_pkg::CMD_CREATE));
    c = random_fields(veht_pkg::CMD_GET); c.entity_id = 6'd63; send_command(c);
    send_command(random_fields(veht_pkg::CMD_FRAME));
    c = on_slot(veht_pkg::CMD_QUERY, 0); c.component_mask = '0; c.tag_mask = '0;
    send_command(c);
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    exp_wr = 0;
    exp_rd = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    free_head = 0;
    free_count = 0;
    slots_used = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_lifecycle(120);
    test_table_full();
    test_random_lifecycle(90);
    release_inputs();
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
